// ===== rtl/nsb_pkg.sv =====
// Package for the N-step SCAN batch scheduler.
// Holds the field widths, the action codes, the controller states and the result record.
// No dependencies; every other file of the block but nsb_track_mem uses it.
package nsb_pkg;

  // Fixed widths of the channel fields.
  localparam int ACTION_W = 2;
  localparam int TRACK_W  = 16;
  localparam int SLOT_W   = 5;
  localparam int STEP_W   = 5;

  // Defaults for the top-level parameters and the batch-size register.
  localparam int DEFAULT_MAX_BATCH  = 16;
  localparam int DEFAULT_TRACK_BITS = 16;
  localparam logic [STEP_W-1:0] DEFAULT_STEP = STEP_W'(4);

  typedef logic [TRACK_W-1:0] track_field_t;
  typedef logic [SLOT_W-1:0]  slot_field_t;
  typedef logic [STEP_W-1:0]  step_field_t;

  // Request action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_TAKE   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT,
    ST_PLACE,
    ST_TAKE,
    ST_DONE
  } state_t;

  // One result record, as it leaves the controller.
  typedef struct packed {
    logic         accepted;
    slot_field_t  slot;
    track_field_t served_track;
    logic         served_valid;
    slot_field_t  remaining;
  } result_t;

endpackage

// ===== rtl/nsb_if.sv =====
// Channel interfaces of the N-step SCAN batch scheduler: request, result and configuration.
// Each carries valid, ready and the payload, with a source and a sink modport.
// Depends on nsb_pkg for the field widths.
interface nsb_req_if;
  logic                          valid;
  logic                          ready;
  logic [nsb_pkg::ACTION_W-1:0]  action;
  logic [nsb_pkg::TRACK_W-1:0]   new_track;
  logic [nsb_pkg::TRACK_W-1:0]   head_track;

  modport source (output valid, output action, output new_track, output head_track,
                  input ready);
  modport sink   (input valid, input action, input new_track, input head_track,
                  output ready);
endinterface

interface nsb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [nsb_pkg::SLOT_W-1:0]  slot;
  logic [nsb_pkg::TRACK_W-1:0] served_track;
  logic                        served_valid;
  logic [nsb_pkg::SLOT_W-1:0]  remaining;

  modport source (output valid, output accepted, output slot, output served_track,
                  output served_valid, output remaining, input ready);
  modport sink   (input valid, input accepted, input slot, input served_track,
                  input served_valid, input remaining, output ready);
endinterface

interface nsb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [nsb_pkg::STEP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/n_step_scan_batch_scheduler_top.sv =====
// Top level of the N-step SCAN batch scheduler: batch-size register, controller,
// track memory and the result output register.
// Depends on nsb_pkg, nsb_if, nsb_track_mem and nsb_ctrl.
//
//   Channel  Modport  Payload                                            Role
//   req      sink     action, new_track, head_track                      request items
//   rsp      source   accepted, slot, served_track, served_valid,        one result per item
//                     remaining
//   cfg      sink     data (batch size limit)                            register write
//
// An insert does one memory read per entry walked, then, unless it lands at the tail, one
// read-write per entry shifted, then the new track's write. The single memory read port
// sets this pace.
// Synchronous reset empties the batch and loads the batch size with 4; the memory is not cleared.
// A result waits in the output register while the next request is worked on; a held register stalls the next result.
module n_step_scan_batch_scheduler_top #(
  parameter int MAX_BATCH  = nsb_pkg::DEFAULT_MAX_BATCH,
  parameter int TRACK_BITS = nsb_pkg::DEFAULT_TRACK_BITS
) (
  input logic        clk,
  input logic        rst,
  nsb_req_if.sink    req,
  nsb_rsp_if.source  rsp,
  nsb_cfg_if.sink    cfg
);

  localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  nsb_pkg::step_field_t step_size;
  nsb_pkg::result_t     res;
  nsb_pkg::result_t     out_q;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [TRACK_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [TRACK_BITS-1:0] mem_rdata;

  // Batch size register; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= nsb_pkg::DEFAULT_STEP;
    end else if (cfg.valid) begin
      step_size <= cfg.data;
    end
  end

  nsb_ctrl #(
    .MAX_BATCH  (MAX_BATCH),
    .TRACK_BITS (TRACK_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .step_size (step_size),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  nsb_track_mem #(
    .DEPTH (MAX_BATCH),
    .WIDTH (TRACK_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a result when empty or when the current one leaves.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.accepted     = out_q.accepted;
  assign rsp.slot         = out_q.slot;
  assign rsp.served_track = out_q.served_track;
  assign rsp.served_valid = out_q.served_valid;
  assign rsp.remaining    = out_q.remaining;

  // An insert result names a slot inside the batch it leaves behind.
  a_slot_in_batch: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.accepted) |-> (rsp.slot < rsp.remaining))
    else $error("inserted slot lies outside the remaining batch");

  // A result never reports both a placed insert and a served take.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.accepted && rsp.served_valid))
    else $error("result reports both an insert and a take");

  // One request at a time: the request channel closes after each transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while the previous one is still in work");

endmodule

// ===== rtl/nsb_track_mem.sv =====
// Track storage of the batch: one write port, one read port, registered read data.
// Entries hold no reset value; only data read from written entries is ever used.
// No package dependencies.
module nsb_track_mem #(
  parameter int  DEPTH = 16,
  parameter int  WIDTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nsb_ctrl.sv =====
// Batch controller: decodes requests, walks the stored batch to find the insert slot,
// shifts the tail, and pops the front through a circular base pointer.
// Depends on nsb_pkg and nsb_if; drives the ports of nsb_track_mem.
module nsb_ctrl #(
  parameter int  MAX_BATCH  = nsb_pkg::DEFAULT_MAX_BATCH,
  parameter int  TRACK_BITS = nsb_pkg::DEFAULT_TRACK_BITS,
  localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1,
  localparam int CW = $clog2(MAX_BATCH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  nsb_req_if.sink                  req,
  input  nsb_pkg::step_field_t     step_size,
  // Result hand-off to the output register.
  output logic                     res_valid,
  input  logic                     res_ready,
  output nsb_pkg::result_t         res,
  // Track memory ports.
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [TRACK_BITS-1:0]    mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  logic [TRACK_BITS-1:0]    mem_rdata
);

  typedef logic [TRACK_BITS-1:0] trk_t;
  typedef logic [CW-1:0]         cnt_t;
  typedef logic [AW-1:0]         addr_t;
  typedef logic [CW:0]           sum_t;

  // Map a position in the batch to a memory address, wrapping at the depth.
  function automatic addr_t phys(input addr_t b, input cnt_t l);
    sum_t s;
    s = sum_t'(b) + sum_t'(l);
    if (s >= sum_t'(MAX_BATCH)) begin
      s = s - sum_t'(MAX_BATCH);
    end
    return addr_t'(s);
  endfunction

  // True when track a lies strictly behind b in the given direction.
  function automatic logic behind(input trk_t a, input trk_t b, input logic up);
    return up ? (a < b) : (a > b);
  endfunction

  function automatic trk_t absdiff(input trk_t a, input trk_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  nsb_pkg::state_t  state, state_next;
  cnt_t             count;
  addr_t            base;
  trk_t             nt;
  trk_t             head;
  trk_t             pos;
  cnt_t             idx;
  cnt_t             k;
  logic             first;
  logic             up;
  logic             skip;
  nsb_pkg::result_t res_q;

  // Walk datapath signals.
  trk_t  t;
  logic  up_c;
  logic  skip_c;
  logic  cont_skip;
  logic  closer;
  logic  walk_adv;
  cnt_t  idx_inc;
  cnt_t  k_dec;
  logic  full;
  logic  req_fire;
  nsb_pkg::action_t act_in;

  assign act_in   = nsb_pkg::action_t'(req.action);
  assign req_fire = req.valid && req.ready;
  assign res      = res_q;

  // Batch limit is the size register saturated to the memory depth.
  always_comb begin
    if (int'(step_size) > MAX_BATCH) begin
      full = (int'(count) >= MAX_BATCH);
    end else begin
      full = (int'(count) >= int'(step_size));
    end
  end

  // One walk step: entry t against the running position.
  always_comb begin
    t         = mem_rdata;
    up_c      = first ? (head < t) : up;
    skip_c    = first ? behind(nt, head, up_c) : skip;
    cont_skip = skip_c && !behind(t, pos, up_c);
    closer    = absdiff(nt, pos) < absdiff(t, pos);
    walk_adv  = cont_skip || !closer;
    idx_inc   = idx + cnt_t'(1);
    k_dec     = k - cnt_t'(1);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      nsb_pkg::ST_IDLE: begin
        if (req.valid) begin
          unique case (act_in)
            nsb_pkg::ACT_INSERT: begin
              if (full) begin
                state_next = nsb_pkg::ST_DONE;
              end else if (count == '0) begin
                state_next = nsb_pkg::ST_PLACE;
              end else begin
                state_next = nsb_pkg::ST_WALK;
              end
            end
            nsb_pkg::ACT_TAKE: begin
              state_next = (count == '0) ? nsb_pkg::ST_DONE : nsb_pkg::ST_TAKE;
            end
            nsb_pkg::ACT_CLEAR, nsb_pkg::ACT_NOP: begin
              state_next = nsb_pkg::ST_DONE;
            end
          endcase
        end
      end
      nsb_pkg::ST_WALK: begin
        if (walk_adv) begin
          state_next = (idx_inc == count) ? nsb_pkg::ST_PLACE : nsb_pkg::ST_WALK;
        end else begin
          state_next = nsb_pkg::ST_SHIFT;
        end
      end
      nsb_pkg::ST_SHIFT: begin
        state_next = (k_dec == idx) ? nsb_pkg::ST_PLACE : nsb_pkg::ST_SHIFT;
      end
      nsb_pkg::ST_PLACE, nsb_pkg::ST_TAKE: begin
        state_next = nsb_pkg::ST_DONE;
      end
      nsb_pkg::ST_DONE: begin
        state_next = res_ready ? nsb_pkg::ST_IDLE : nsb_pkg::ST_DONE;
      end
      default: begin
        state_next = nsb_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake and memory port control.
  always_comb begin
    req.ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = phys(base, idx);
    mem_wdata = nt;
    mem_raddr = base;
    unique case (state)
      nsb_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        mem_raddr = base;
      end
      nsb_pkg::ST_WALK: begin
        mem_raddr = walk_adv ? phys(base, idx_inc) : phys(base, count - cnt_t'(1));
      end
      nsb_pkg::ST_SHIFT: begin
        // Move entry k-1 up to k and fetch entry k-2 for the next step.
        mem_we    = 1'b1;
        mem_waddr = phys(base, k);
        mem_wdata = mem_rdata;
        mem_raddr = (k_dec == idx) ? base : phys(base, k - cnt_t'(2));
      end
      nsb_pkg::ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = phys(base, idx);
        mem_wdata = nt;
      end
      nsb_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // State, batch bookkeeping and walk registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsb_pkg::ST_IDLE;
      count <= '0;
      base  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        nsb_pkg::ST_IDLE: begin
          if (req_fire) begin
            nt    <= trk_t'(req.new_track);
            head  <= trk_t'(req.head_track);
            pos   <= trk_t'(req.head_track);
            idx   <= '0;
            first <= 1'b1;
            skip  <= 1'b0;
            // A clear reports the emptied batch; the rest start from the current fill.
            res_q <= '{accepted: 1'b0, slot: nsb_pkg::slot_field_t'(0),
                       served_track: nsb_pkg::track_field_t'(0), served_valid: 1'b0,
                       remaining: (act_in == nsb_pkg::ACT_CLEAR) ?
                                  nsb_pkg::slot_field_t'(0) : nsb_pkg::slot_field_t'(count)};
            if (act_in == nsb_pkg::ACT_CLEAR) begin
              count <= '0;
            end
          end
        end
        nsb_pkg::ST_WALK: begin
          first <= 1'b0;
          up    <= up_c;
          skip  <= cont_skip;
          if (walk_adv) begin
            pos <= t;
            idx <= idx_inc;
          end else begin
            k <= count;
          end
        end
        nsb_pkg::ST_SHIFT: begin
          k <= k_dec;
        end
        nsb_pkg::ST_PLACE: begin
          count              <= count + cnt_t'(1);
          res_q.accepted     <= 1'b1;
          res_q.slot         <= nsb_pkg::slot_field_t'(idx);
          res_q.remaining    <= nsb_pkg::slot_field_t'(count + cnt_t'(1));
        end
        nsb_pkg::ST_TAKE: begin
          base               <= phys(base, cnt_t'(1));
          count              <= count - cnt_t'(1);
          res_q.served_track <= nsb_pkg::track_field_t'(mem_rdata);
          res_q.served_valid <= 1'b1;
          res_q.remaining    <= nsb_pkg::slot_field_t'(count - cnt_t'(1));
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule

// ===== sim/n_step_scan_batch_scheduler_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the N-step SCAN batch scheduler top level.
// Depends on nsb_pkg, the nsb_if channel interfaces and n_step_scan_batch_scheduler_top.
module n_step_scan_batch_scheduler_top_test;

  localparam int MAX_BATCH   = nsb_pkg::DEFAULT_MAX_BATCH;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam int DIR_N       = 25;
  localparam int PHASE_N     = 8;

  // One row of the directed stimulus; the result is typed in only where it is obvious.
  typedef struct {
    nsb_pkg::action_t      act;
    nsb_pkg::track_field_t nt;
    nsb_pkg::track_field_t hd;
    bit                    known;
    nsb_pkg::result_t      res;
  } dir_row_t;

  logic clk;
  logic rst;

  nsb_req_if req_ch ();
  nsb_rsp_if rsp_ch ();
  nsb_cfg_if cfg_ch ();

  n_step_scan_batch_scheduler_top #(
    .MAX_BATCH  (MAX_BATCH),
    .TRACK_BITS (nsb_pkg::DEFAULT_TRACK_BITS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the batch, its fill level and the batch-size register.
  nsb_pkg::track_field_t batch_trk [MAX_BATCH];
  int                    batch_len;
  int                    step_reg;

  nsb_pkg::result_t      pending_q [$];
  int                    err_cnt;
  int                    idle_cnt;
  nsb_pkg::result_t      rsp_want;

  dir_row_t dir_tab [DIR_N] = '{
    '{nsb_pkg::ACT_TAKE,   16'd0,     16'd0,     1'b1, '{1'b0, 5'd0, 16'd0, 1'b0, 5'd0}},
    '{nsb_pkg::ACT_NOP,    16'hFFFF,  16'hFFFF,  1'b1, '{1'b0, 5'd0, 16'd0, 1'b0, 5'd0}},
    '{nsb_pkg::ACT_INSERT, 16'd100,   16'd50,    1'b1, '{1'b1, 5'd0, 16'd0, 1'b0, 5'd1}},
    '{nsb_pkg::ACT_INSERT, 16'd65535, 16'd0,     1'b0, '0},
    '{nsb_pkg::ACT_INSERT, 16'd0,     16'd65535, 1'b0, '0},
    '{nsb_pkg::ACT_INSERT, 16'd80,    16'd90,    1'b0, '0},
    '{nsb_pkg::ACT_INSERT, 16'd5,     16'd5,     1'b1, '{1'b0, 5'd0, 16'd0, 1'b0, 5'd4}},
    '{nsb_pkg::ACT_TAKE,   16'd0,     16'd0,     1'b0, '0},
    '{nsb_pkg::ACT_TAKE,   16'd0,     16'd0,     1'b0, '0},
    '{nsb_pkg::ACT_TAKE,   16'd0,     16'd0,     1'b0, '0},
    '{nsb_pkg::ACT_TAKE,   16'd0,     16'd0,     1'b0, '0},
    '{nsb_pkg::ACT_TAKE,   16'hFFFF,  16'hFFFF,  1'b1, '{1'b0, 5'd0, 16'd0, 1'b0, 5'd0}},
    '{nsb_pkg::ACT_INSERT, 16'd200,   16'd100,   1'b1, '{1'b1, 5'd0, 16'd0, 1'b0, 5'd1}},
    '{nsb_pkg::ACT_INSERT, 16'd300,   16'd100,   1'b0, '0},
    '{nsb_pkg::ACT_INSERT, 16'd50,    16'd100,   1'b0, '0},
    '{nsb_pkg::ACT_INSERT, 16'd500,   16'd400,   1'b0, '0},
    '{nsb_pkg::ACT_CLEAR,  16'h1234,  16'h4321,  1'b1, '{1'b0, 5'd0, 16'd0, 1'b0, 5'd0}},
    '{nsb_pkg::ACT_INSERT, 16'd1000,  16'd1000,  1'b1, '{1'b1, 5'd0, 16'd0, 1'b0, 5'd1}},
    '{nsb_pkg::ACT_INSERT, 16'd1010,  16'd1005,  1'b0, '0},
    '{nsb_pkg::ACT_INSERT, 16'd990,   16'd1000,  1'b0, '0},
    '{nsb_pkg::ACT_INSERT, 16'd1020,  16'd1030,  1'b0, '0},
    '{nsb_pkg::ACT_INSERT, 16'd0,     16'd0,     1'b1, '{1'b0, 5'd0, 16'd0, 1'b0, 5'd4}},
    '{nsb_pkg::ACT_CLEAR,  16'd0,     16'd0,     1'b1, '{1'b0, 5'd0, 16'd0, 1'b0, 5'd0}},
    '{nsb_pkg::ACT_INSERT, 16'h5555,  16'hAAAA,  1'b1, '{1'b1, 5'd0, 16'd0, 1'b0, 5'd1}},
    '{nsb_pkg::ACT_TAKE,   16'hAAAA,  16'h5555,  1'b1, '{1'b0, 5'd0, 16'h5555, 1'b1, 5'd0}}
  };

  // Batch-size settings and item counts of the random phases.
  int phase_step  [PHASE_N] = '{16, 1, 0, 31, 9, 2, 16, 5};
  int phase_items [PHASE_N] = '{300, 200, 80, 300, 260, 220, 300, 240};

  // Distance between two tracks.
  function automatic int track_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // True when track a lies strictly behind b for the sweep direction.
  function automatic bit lies_behind(int a, int b, bit up);
    return up ? (a < b) : (a > b);
  endfunction

  // Applies one request to the shadow batch and returns the result it should produce.
  function automatic nsb_pkg::result_t sched_predict(nsb_pkg::action_t act,
                                                     nsb_pkg::track_field_t nt,
                                                     nsb_pkg::track_field_t hd);
    nsb_pkg::result_t res;
    int               lim;
    int               idx;
    int               pos;
    int               k;
    bit               up;
    res = '0;
    lim = (step_reg > MAX_BATCH) ? MAX_BATCH : step_reg;
    case (act)
      nsb_pkg::ACT_INSERT: begin
        if (batch_len < lim) begin
          idx = 0;
          pos = int'(hd);
          up  = (batch_len > 0) && (int'(hd) < int'(batch_trk[0]));
          // A request behind the head first passes the entries still moving the sweep way.
          if (lies_behind(int'(nt), pos, up)) begin
            while (idx < batch_len) begin
              if (lies_behind(int'(batch_trk[idx]), pos, up)) break;
              pos = int'(batch_trk[idx]);
              idx++;
            end
          end
          // Then walk until the new track is strictly nearer than the next entry.
          while (idx < batch_len) begin
            if (track_gap(int'(nt), pos) < track_gap(int'(batch_trk[idx]), pos)) break;
            pos = int'(batch_trk[idx]);
            idx++;
          end
          for (k = batch_len; k > idx; k--) batch_trk[k] = batch_trk[k-1];
          batch_trk[idx] = nt;
          batch_len++;
          res.accepted = 1'b1;
          res.slot     = nsb_pkg::SLOT_W'(idx);
        end
      end
      nsb_pkg::ACT_TAKE: begin
        if (batch_len > 0) begin
          res.served_track = batch_trk[0];
          res.served_valid = 1'b1;
          for (k = 1; k < batch_len; k++) batch_trk[k-1] = batch_trk[k];
          batch_len--;
        end
      end
      nsb_pkg::ACT_CLEAR: begin
        batch_len = 0;
      end
      default: begin
      end
    endcase
    res.remaining = nsb_pkg::SLOT_W'(batch_len);
    return res;
  endfunction

  // Presents one request, waits for its transaction and records the expected result.
  task automatic issue_request(nsb_pkg::action_t act, nsb_pkg::track_field_t nt,
                               nsb_pkg::track_field_t hd, bit known,
                               nsb_pkg::result_t typed);
    nsb_pkg::result_t want;
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.new_track  <= nt;
    req_ch.head_track <= hd;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    want = sched_predict(act, nt, hd);
    if (known) want = typed;
    pending_q.push_back(want);
  endtask

  // Writes the batch-size register once every expected result has come back.
  task automatic write_step(int value);
    while (pending_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= nsb_pkg::STEP_W'(value);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    step_reg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Picks a track: now and then near either end, else full range or, when narrow, a window that forces ties.
  function automatic nsb_pkg::track_field_t pick_track(bit narrow);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return (r < 4) ? nsb_pkg::track_field_t'($urandom_range(0, 1))
                              : nsb_pkg::track_field_t'($urandom_range(65534, 65535));
    if (narrow) return nsb_pkg::track_field_t'($urandom_range(0, 20));
    return nsb_pkg::track_field_t'($urandom_range(0, 65535));
  endfunction

  // Reports one field that differs from its expectation.
  task automatic report_field(string fname, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result checker: each transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with no expectation waiting, actual remaining %0d",
                 $time, rsp_ch.remaining);
        err_cnt++;
      end else begin
        rsp_want = pending_q.pop_front();
        report_field("accepted",     16'(rsp_want.accepted),     16'(rsp_ch.accepted));
        report_field("slot",         16'(rsp_want.slot),         16'(rsp_ch.slot));
        report_field("served_track", rsp_want.served_track,      rsp_ch.served_track);
        report_field("served_valid", 16'(rsp_want.served_valid), 16'(rsp_ch.served_valid));
        report_field("remaining",    16'(rsp_want.remaining),    16'(rsp_ch.remaining));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cnt <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Result receiver: stretches of full rate, random stalls and long stalls.
  initial begin : rsp_stall
    int mode;
    int len;
    int j;
    rsp_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(1, 40);
      for (j = 0; j < len; j++) begin
        @(negedge clk);
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= (j == len - 1);
        endcase
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases at several batch sizes.
  initial begin : stimulus
    int               ph;
    int               n;
    int               ins_pct;
    int               burst_left;
    int               gap;
    int               r;
    bit               narrow;
    nsb_pkg::action_t act;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.action     = nsb_pkg::ACT_NOP;
    req_ch.new_track  = '0;
    req_ch.head_track = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    err_cnt           = 0;
    batch_len         = 0;
    step_reg          = int'(nsb_pkg::DEFAULT_STEP);
    ins_pct           = 50;
    narrow            = 1'b0;
    burst_left        = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset batch size.
    for (n = 0; n < DIR_N; n++) begin
      issue_request(dir_tab[n].act, dir_tab[n].nt, dir_tab[n].hd, dir_tab[n].known,
                    dir_tab[n].res);
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Random part: the insert share moves between filling, draining and balanced runs.
    for (ph = 0; ph < PHASE_N; ph++) begin
      write_step((ph == PHASE_N - 1) ? $urandom_range(1, 15) : phase_step[ph]);
      for (n = 0; n < phase_items[ph]; n++) begin
        if (n % 16 == 0) begin
          r       = $urandom_range(0, 2);
          ins_pct = (r == 0) ? 75 : ((r == 1) ? 25 : 50);
          narrow  = ($urandom_range(0, 9) < 3);
        end
        r = $urandom_range(0, 99);
        if (r < ins_pct)  act = nsb_pkg::ACT_INSERT;
        else if (r < 96)  act = nsb_pkg::ACT_TAKE;
        else if (r < 98)  act = nsb_pkg::ACT_CLEAR;
        else              act = nsb_pkg::ACT_NOP;
        if (act == nsb_pkg::ACT_INSERT)
          issue_request(act, pick_track(narrow), pick_track(narrow), 1'b0, '0);
        else
          issue_request(act, nsb_pkg::track_field_t'($urandom_range(0, 65535)),
                        nsb_pkg::track_field_t'($urandom_range(0, 65535)), 1'b0, '0);
        // Sender bursts with idle gaps, and now and then a long burst with none.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end else begin
          burst_left--;
        end
      end
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end

    // Drain, then give the block time to show any stray result.
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
